/* rtl/kda_pkg.sv */
package kda_pkg;

  localparam int unsigned TimerW = 16;
  localparam int unsigned PortW  = 8;
  localparam int unsigned PhaseW = 3;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_DEBOUNCE_TICKS = 2'd0,
    CFG_SETTLE_TICKS   = 2'd1,
    CFG_DEF_PERIOD     = 2'd2,
    CFG_DEF_DELAY      = 2'd3
  } cfg_idx_e;

  localparam logic [TimerW-1:0] DebounceTicksRst = 16'd5;
  localparam logic [TimerW-1:0] SettleTicksRst   = 16'd3;
  localparam logic [TimerW-1:0] DefPeriodRst     = 16'd20;
  localparam logic [TimerW-1:0] DefDelayRst      = 16'd150;

  // Reported phase codes
  localparam logic [PhaseW-1:0] PhCodeIdle   = 3'd0;
  localparam logic [PhaseW-1:0] PhCodeDeb    = 3'd1;
  localparam logic [PhaseW-1:0] PhCodeSettle = 3'd2;
  localparam logic [PhaseW-1:0] PhCodeWait   = 3'd3;
  localparam logic [PhaseW-1:0] PhCodeRep    = 3'd4;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_DEB    = 5'b00010,
    PH_SETTLE = 5'b00100,
    PH_WAIT   = 5'b01000,
    PH_REP    = 5'b10000
  } phase_e;

  typedef struct packed {
    logic              action;
    logic [PortW-1:0]  port_bits;
    logic [PortW-1:0]  key_sel;
    logic [TimerW-1:0] repeat_period;
    logic [TimerW-1:0] repeat_delay;
  } in_item_t;

  typedef struct packed {
    logic              push_event;
    logic              repeat_event;
    logic              ignored;
    logic [PhaseW-1:0] phase_now;
  } out_item_t;

  typedef struct packed {
    logic [TimerW-1:0] debounce_ticks;
    logic [TimerW-1:0] settle_ticks;
    logic [TimerW-1:0] def_period;
    logic [TimerW-1:0] def_delay;
  } kda_cfg_t;

  function automatic logic [PhaseW-1:0] phase_code(phase_e ph);
    logic [PhaseW-1:0] code;
    unique case (ph)
      PH_IDLE:   code = PhCodeIdle;
      PH_DEB:    code = PhCodeDeb;
      PH_SETTLE: code = PhCodeSettle;
      PH_WAIT:   code = PhCodeWait;
      PH_REP:    code = PhCodeRep;
      default:   code = PhCodeIdle;
    endcase
    return code;
  endfunction

endpackage

/* rtl/key_debounce_autorepeat.sv */
// Push-button qualifier with auto-repeat, one shared machine for all keys.
// Input channel (in_valid_i / in_stall_o / in_item_i): each transaction is
//   either a timer tick (action = 0) that counts the shared countdown down,
//   or a poll (action = 1) of one key: port byte, key mask, repeat timings.
// Output channel (out_valid_o / out_stall_i / out_item_o): exactly one
//   result transaction per input transaction, in order: push, repeat and
//   ignored flags plus the phase after the item.
// The result is written into the output register when the input
//   transaction is accepted. Throughput: one transaction per cycle while
//   the output is not stalled; the phase/countdown update feeds that register.
// Stall: the output register holds its result while out_stall_i is high;
//   in_stall_o rises only when that register is full and stalled, so a new
//   transaction is taken in the same cycle that the old result drains.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_index_i
//   (debounce ticks, settle ticks, default period, default delay); write
//   only while the block is idle.
// Reset: rst_ni clears the phase to idle, unlocks the key, zeroes the
//   countdown, empties the output register and loads the register defaults.
module key_debounce_autorepeat (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  kda_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output kda_pkg::out_item_t  out_item_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [15:0]         cfg_wdata_i
);
  import kda_pkg::*;

  kda_cfg_t  cfg;
  out_item_t result;
  out_item_t out_item_q;
  logic      out_valid_q, out_valid_d;
  logic      in_accept;

  // Stall the input only when a finished result is stuck in the output register
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  kda_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Advance the machine once per accepted transaction
  kda_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (in_accept),
    .item_i    (in_item_i),
    .cfg_i     (cfg),
    .result_o  (result)
  );

  // Hold the result until taken; load a new one on every accept
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

/* rtl/kda_cfg_regs.sv */
module kda_cfg_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_index_i,
  input  logic [15:0]               cfg_wdata_i,
  output kda_pkg::kda_cfg_t         cfg_o
);
  import kda_pkg::*;

  kda_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_DEBOUNCE_TICKS: cfg_d.debounce_ticks = cfg_wdata_i;
        CFG_SETTLE_TICKS:   cfg_d.settle_ticks   = cfg_wdata_i;
        CFG_DEF_PERIOD:     cfg_d.def_period     = cfg_wdata_i;
        CFG_DEF_DELAY:      cfg_d.def_delay      = cfg_wdata_i;
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks <= DebounceTicksRst;
      cfg_q.settle_ticks   <= SettleTicksRst;
      cfg_q.def_period     <= DefPeriodRst;
      cfg_q.def_delay      <= DefDelayRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/kda_step.sv */
module kda_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_en_i,
  input  kda_pkg::in_item_t   item_i,
  input  kda_pkg::kda_cfg_t   cfg_i,
  output kda_pkg::out_item_t  result_o
);
  import kda_pkg::*;

  phase_e            phase_q, phase_d;
  logic [PortW-1:0]  key_q, key_d;
  logic [TimerW-1:0] cnt_q, cnt_d;
  logic [TimerW-1:0] period;
  logic [TimerW-1:0] delay;
  logic              press;
  logic              expired;
  logic              blocked;
  logic              push, rep, ign;

  assign period  = (item_i.repeat_period == '0) ? cfg_i.def_period : item_i.repeat_period;
  assign delay   = (item_i.repeat_delay == '0) ? cfg_i.def_delay : item_i.repeat_delay;
  assign press   = (item_i.port_bits & item_i.key_sel) == '0;
  assign expired = cnt_q == '0;
  assign blocked = (key_q != '0) && (key_q != item_i.key_sel);

  always_comb begin
    phase_d = phase_q;
    key_d   = key_q;
    cnt_d   = cnt_q;
    push    = 1'b0;
    rep     = 1'b0;
    ign     = 1'b0;
    if (step_en_i) begin
      if (!item_i.action) begin
        // timer tick: count down toward zero
        if (!expired) begin
          cnt_d = cnt_q - 1'b1;
        end
      end else if (blocked) begin
        ign = 1'b1;
      end else begin
        unique case (phase_q)
          PH_IDLE: begin
            if (press) begin
              phase_d = PH_DEB;
              cnt_d   = cfg_i.debounce_ticks;
            end
          end
          PH_DEB: begin
            // a release here leaves the machine in debounce
            if (press && expired) begin
              phase_d = PH_SETTLE;
              cnt_d   = cfg_i.settle_ticks;
              key_d   = item_i.key_sel;
            end
          end
          PH_SETTLE: begin
            if (!press) begin
              push    = 1'b1;
              phase_d = PH_IDLE;
              key_d   = '0;
            end else if (expired) begin
              phase_d = PH_WAIT;
              cnt_d   = delay;
            end
          end
          PH_WAIT: begin
            if (!press) begin
              push    = 1'b1;
              phase_d = PH_IDLE;
              key_d   = '0;
            end else if (expired) begin
              phase_d = PH_REP;
            end
          end
          PH_REP: begin
            if (!press) begin
              phase_d = PH_IDLE;
              key_d   = '0;
            end else if (expired) begin
              cnt_d = period;
              rep   = 1'b1;
            end
          end
          default: phase_d = PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      key_q   <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      key_q   <= key_d;
      cnt_q   <= cnt_d;
    end
  end

  assign result_o.push_event   = push;
  assign result_o.repeat_event = rep;
  assign result_o.ignored      = ign;
  assign result_o.phase_now    = phase_code(phase_d);

endmodule
